// ===== sv/proxy_header_parser_top_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the PROXY header parser
// Shared concurrent assertion forms, clocked on clk, quiet in reset.
// ----------------------------------------------------------------------------
`ifndef PROXY_HEADER_PARSER_TOP_MACROS_SVH
`define PROXY_HEADER_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define PHP_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("php assertion failed");

// next-cycle implication
`define PHP_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("php assertion failed");

`endif

// ===== sv/php_pkg.sv =====
// ----------------------------------------------------------------------------
// PROXY header parser package
// Types, codes and constants shared by the parser modules.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package php_pkg;

    localparam int V1_MAX_LINE = 107;
    localparam int IQ_DEPTH    = 4;
    localparam int IQ_AW       = $clog2(IQ_DEPTH);
    localparam int RB_DEPTH    = 2;

    localparam logic [7:0] CH_P     = 8'h50;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_SPACE = 8'h20;

    localparam logic [3:0] GAP_NONE = 4'hF;

    localparam logic [3:0] ERR_NONE      = 4'd0;
    localparam logic [3:0] ERR_FIRST     = 4'd1;
    localparam logic [3:0] ERR_LONG      = 4'd2;
    localparam logic [3:0] ERR_BARE_LF   = 4'd3;
    localparam logic [3:0] ERR_SPACING   = 4'd4;
    localparam logic [3:0] ERR_MALFORMED = 4'd5;
    localparam logic [3:0] ERR_FAMILY    = 4'd6;
    localparam logic [3:0] ERR_TOKENS    = 4'd7;
    localparam logic [3:0] ERR_ADDR      = 4'd8;
    localparam logic [3:0] ERR_MISMATCH  = 4'd9;
    localparam logic [3:0] ERR_PORT      = 4'd10;
    localparam logic [3:0] ERR_SIG       = 4'd11;
    localparam logic [3:0] ERR_VERSION   = 4'd12;
    localparam logic [3:0] ERR_COMMAND   = 4'd13;
    localparam logic [3:0] ERR_V4_SHORT  = 4'd14;
    localparam logic [3:0] ERR_V6_SHORT  = 4'd15;

    typedef enum logic [1:0] {
        PH_IDLE,
        PH_V1,
        PH_V2
    } php_phase_t;

    typedef enum logic [1:0] {
        CLS_TEXT,
        CLS_SPACE,
        CLS_CR,
        CLS_LF
    } php_cls_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first;
        php_cls_t   cls;
        php_phase_t start;
    } php_item_t;

    typedef struct packed {
        logic        status;
        logic [3:0]  error_code;
        logic        has_source;
        logic        source_is_ipv6;
        logic [63:0] source_addr_high;
        logic [63:0] source_addr_low;
        logic [15:0] source_port;
        logic [16:0] header_length;
    } php_res_t;

    typedef struct packed {
        logic [16:0]       bc;
        logic              sig_ok;
        logic [7:0]        cmd;
        logic [7:0]        fam;
        logic [15:0]       blen;
        logic [2:0]        tidx;
        logic [6:0]        tlen;
        logic [7:0]        tm;
        logic [9:0]        ef;
        logic              prev_cr;
        logic [16:0]       acc;
        logic [3:0]        gc;
        logic [3:0]        gap;
        logic [2:0]        dc;
        logic [1:0]        ak;
        logic [63:0]       cap_hi;
        logic [63:0]       cap_lo;
        logic [15:0]       cap_port;
        logic [7:0][15:0]  head;
        logic [127:0]      tail;
    } php_ctx_t;

    function automatic php_ctx_t ctx_clear();
        php_ctx_t c;
        c        = '0;
        c.sig_ok = 1'b1;
        c.gap    = GAP_NONE;
        return c;
    endfunction

endpackage

`default_nettype wire

// ===== sv/php_front.sv =====
// ----------------------------------------------------------------------------
// PROXY header parser front end
// Classifies each incoming byte for the parser core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module php_front
    import php_pkg::*;
(
    input  wire logic [7:0] data_byte,
    input  wire logic       first,
    output php_item_t       item
);

    always_comb
    begin
        item.data_byte = data_byte;
        item.first     = first;
        unique case (data_byte)
            CH_LF:    item.cls = CLS_LF;
            CH_CR:    item.cls = CLS_CR;
            CH_SPACE: item.cls = CLS_SPACE;
            default:  item.cls = CLS_TEXT;
        endcase
        unique case (data_byte)
            CH_P:    item.start = PH_V1;
            CH_CR:   item.start = PH_V2;
            default: item.start = PH_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/php_item_queue.sv =====
// ----------------------------------------------------------------------------
// PROXY header parser item queue
// Short queue between the classifier and the parser core.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "proxy_header_parser_top_macros.svh"

module php_item_queue
    import php_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  wire logic  push,
    input  php_item_t  wr_item,
    output logic       full,
    input  wire logic  pop,
    output php_item_t  rd_item,
    output logic       empty
);

    php_item_t        mem_reg [IQ_DEPTH];
    logic [IQ_AW-1:0] wr_ptr_reg;
    logic [IQ_AW-1:0] wr_ptr_next;
    logic [IQ_AW-1:0] rd_ptr_reg;
    logic [IQ_AW-1:0] rd_ptr_next;
    logic [IQ_AW:0]   count_reg;
    logic [IQ_AW:0]   count_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (count_reg == (IQ_AW+1)'(IQ_DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rd_item = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_item;
        end
    end

    `PHP_ASSERT_IMP(a_iq_bound, 1'b1, count_reg <= (IQ_AW+1)'(IQ_DEPTH))
    `PHP_ASSERT_NXT(a_iq_grow, do_push && !do_pop, count_reg == $past(count_reg) + 1'b1)

endmodule

`default_nettype wire

// ===== sv/php_back.sv =====
// ----------------------------------------------------------------------------
// PROXY header parser core
// Runs the v1 text and v2 binary header checks, one byte per cycle while the result buffer has room.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "proxy_header_parser_top_macros.svh"

module php_back
    import php_pkg::*;
(
    input  wire logic  clk,
    input  wire logic  rst_n,
    input  php_item_t  item,
    input  wire logic  item_empty,
    output logic       item_pop,
    output php_res_t   res,
    output logic       res_empty,
    input  wire logic  res_pop
);

    localparam logic [7:0] TM_PROXY   = 8'h01;
    localparam logic [7:0] TM_UNKNOWN = 8'h02;
    localparam logic [7:0] TM_TCP4    = 8'h04;
    localparam logic [7:0] TM_TCP6    = 8'h08;
    localparam logic [7:0] TM_DOT     = 8'h10;
    localparam logic [7:0] TM_COLON   = 8'h20;
    localparam logic [7:0] TM_LETTER  = 8'h40;
    localparam logic [7:0] TM_COLPREV = 8'h80;

    localparam logic [9:0] EF_SPACING = 10'h001;
    localparam logic [9:0] EF_PROXY   = 10'h002;
    localparam logic [9:0] EF_SRCADDR = 10'h004;
    localparam logic [9:0] EF_DSTADDR = 10'h008;
    localparam logic [9:0] EF_SRCPORT = 10'h010;
    localparam logic [9:0] EF_DSTPORT = 10'h020;
    localparam logic [9:0] EF_TOKBAD  = 10'h040;
    localparam logic [9:0] EF_GAPJUST = 10'h080;
    localparam logic [9:0] EF_LEADCOL = 10'h100;

    php_phase_t phase_reg;
    php_phase_t phase_next;
    php_phase_t eff_phase;
    php_ctx_t   ctx_reg;
    php_ctx_t   ctx_next;
    php_res_t   res_data;
    logic       res_make;
    logic       take;

    php_res_t   rb_reg [RB_DEPTH];
    logic       rb_wr_reg;
    logic       rb_rd_reg;
    logic [1:0] res_count_reg;
    logic [1:0] res_count_next;
    logic       rb_push;
    logic       rb_pop;

    function automatic logic [7:0] sig_byte(input logic [3:0] i);
        logic [7:0] v;
        case (i)
            4'd0:    v = 8'h0D;
            4'd1:    v = 8'h0A;
            4'd2:    v = 8'h0D;
            4'd3:    v = 8'h0A;
            4'd4:    v = 8'h00;
            4'd5:    v = 8'h0D;
            4'd6:    v = 8'h0A;
            4'd7:    v = 8'h51;
            4'd8:    v = 8'h55;
            4'd9:    v = 8'h49;
            4'd10:   v = 8'h54;
            default: v = 8'h0A;
        endcase
        return v;
    endfunction

    function automatic logic [7:0] proxy_chr(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = "P";
            3'd1:    v = "R";
            3'd2:    v = "O";
            3'd3:    v = "X";
            default: v = "Y";
        endcase
        return v;
    endfunction

    function automatic logic [7:0] unknown_chr(input logic [2:0] i);
        logic [7:0] v;
        case (i)
            3'd0:    v = "U";
            3'd1:    v = "N";
            3'd2:    v = "K";
            3'd3:    v = "N";
            3'd4:    v = "O";
            3'd5:    v = "W";
            default: v = "N";
        endcase
        return v;
    endfunction

    function automatic logic [7:0] tcp_chr(input logic [1:0] i);
        logic [7:0] v;
        case (i)
            2'd0:    v = "T";
            2'd1:    v = "C";
            default: v = "P";
        endcase
        return v;
    endfunction

    function automatic logic [4:0] hex_nib(input logic [7:0] ch);
        logic [4:0] v;
        if (ch >= "0" && ch <= "9")
        begin
            v = {1'b0, ch[3:0]};
        end
        else if ((ch >= "a" && ch <= "f") || (ch >= "A" && ch <= "F"))
        begin
            v = {1'b0, 4'(ch[3:0] + 4'd9)};
        end
        else
        begin
            v = 5'h10;
        end
        return v;
    endfunction

    function automatic php_ctx_t f_reset_group(input php_ctx_t c);
        c.acc = '0;
        c.dc  = '0;
        c.tm  = c.tm & ~TM_LETTER;
        return c;
    endfunction

    function automatic php_ctx_t f_end_v4(input php_ctx_t c);
        logic [10:0] dec;
        dec = 11'(c.acc[11:8]) * 11'd100 + 11'(c.acc[7:4]) * 11'd10 + 11'(c.acc[3:0]);
        if (c.dc == 3'd0 || c.dc > 3'd3 || (c.tm & TM_LETTER) != '0 || dec > 11'd255
            || c.gc >= 4'd4)
        begin
            c.ef = c.ef | EF_TOKBAD;
        end
        else
        begin
            c.head[c.gc[2:0]] = {8'd0, dec[7:0]};
            c.gc = c.gc + 4'd1;
        end
        return f_reset_group(c);
    endfunction

    function automatic php_ctx_t f_store_v6(input php_ctx_t c);
        if (c.gc >= 4'd8)
        begin
            c.ef = c.ef | EF_TOKBAD;
        end
        else
        begin
            if (c.gap == GAP_NONE)
            begin
                c.head[c.gc[2:0]] = c.acc[15:0];
            end
            else
            begin
                c.tail = {c.tail[111:0], c.acc[15:0]};
            end
            c.gc = c.gc + 4'd1;
        end
        return f_reset_group(c);
    endfunction

    function automatic php_ctx_t f_addr_char(input php_ctx_t c, input logic [7:0] ch);
        logic [4:0] nib;
        nib = hex_nib(ch);
        if ((c.ef & EF_TOKBAD) != '0)
        begin
            c.ef = c.ef;
        end
        else if ((c.ef & EF_LEADCOL) != '0 && ch != ":")
        begin
            c.ef = c.ef | EF_TOKBAD;
        end
        else if (!nib[4])
        begin
            if (c.dc >= 3'd4)
            begin
                c.ef = c.ef | EF_TOKBAD;
            end
            else
            begin
                c.acc = {1'b0, c.acc[11:0], nib[3:0]};
                c.dc  = c.dc + 3'd1;
                if (nib[3:0] > 4'd9)
                begin
                    c.tm = c.tm | TM_LETTER;
                end
                c.tm = c.tm & ~TM_COLPREV;
                c.ef = c.ef & ~EF_GAPJUST;
            end
        end
        else if (ch == ".")
        begin
            if ((c.tm & TM_COLON) != '0)
            begin
                c.ef = c.ef | EF_TOKBAD;
            end
            else
            begin
                c    = f_end_v4(c);
                c.tm = c.tm | TM_DOT;
            end
        end
        else if (ch == ":")
        begin
            if ((c.tm & TM_DOT) != '0)
            begin
                c.ef = c.ef | EF_TOKBAD;
            end
            else if ((c.tm & TM_COLPREV) != '0)
            begin
                if (c.gap != GAP_NONE)
                begin
                    c.ef = c.ef | EF_TOKBAD;
                end
                else
                begin
                    c.gap = c.gc;
                    c.ef  = (c.ef | EF_GAPJUST) & ~EF_LEADCOL;
                    c.tm  = c.tm | TM_COLON | TM_COLPREV;
                end
            end
            else if (c.dc == 3'd0)
            begin
                if (c.tlen == 7'd1)
                begin
                    c.ef = c.ef | EF_LEADCOL;
                    c.tm = c.tm | TM_COLON | TM_COLPREV;
                end
                else
                begin
                    c.ef = c.ef | EF_TOKBAD;
                end
            end
            else
            begin
                c    = f_store_v6(c);
                c.tm = c.tm | TM_COLON | TM_COLPREV;
            end
        end
        else
        begin
            c.ef = c.ef | EF_TOKBAD;
        end
        return c;
    endfunction

    function automatic php_ctx_t f_addr_finish(input php_ctx_t c, input logic is_src);
        logic        v6;
        logic [63:0] hi;
        logic [63:0] lo;
        logic [3:0]  n;
        logic [3:0]  gp;
        logic [4:0]  pos_sum;
        logic [15:0] fw [8];
        v6 = 1'b0;
        hi = '0;
        lo = '0;
        for (int k = 0; k < 8; k++)
        begin
            fw[k] = '0;
        end
        if ((c.ef & EF_LEADCOL) != '0)
        begin
            c.ef = c.ef | EF_TOKBAD;
        end
        if ((c.ef & EF_TOKBAD) == '0)
        begin
            if ((c.tm & TM_DOT) != '0)
            begin
                c = f_end_v4(c);
                if (c.gc != 4'd4)
                begin
                    c.ef = c.ef | EF_TOKBAD;
                end
                lo = {32'd0, c.head[0][7:0], c.head[1][7:0], c.head[2][7:0], c.head[3][7:0]};
            end
            else if ((c.tm & TM_COLON) != '0)
            begin
                v6 = 1'b1;
                if (c.dc != 3'd0)
                begin
                    c = f_store_v6(c);
                end
                else if ((c.ef & EF_GAPJUST) == '0)
                begin
                    c.ef = c.ef | EF_TOKBAD;
                end
                n = (c.gc > 4'd8) ? 4'd8 : c.gc;
                if ((c.gap == GAP_NONE) ? (n != 4'd8) : (n > 4'd7))
                begin
                    c.ef = c.ef | EF_TOKBAD;
                end
                gp = (c.gap == GAP_NONE || c.gap > n) ? n : c.gap;
                for (int k = 0; k < 8; k++)
                begin
                    pos_sum = 5'(k) + {1'b0, n} - {1'b0, gp};
                    if (4'(k) < gp)
                    begin
                        fw[k] = c.head[k];
                    end
                    else if (pos_sum >= 5'd8)
                    begin
                        fw[k] = c.tail[16*(7-k) +: 16];
                    end
                end
                hi = {fw[0], fw[1], fw[2], fw[3]};
                lo = {fw[4], fw[5], fw[6], fw[7]};
            end
            else
            begin
                c.ef = c.ef | EF_TOKBAD;
            end
        end
        if ((c.ef & EF_TOKBAD) != '0)
        begin
            c.ef = c.ef | (is_src ? EF_SRCADDR : EF_DSTADDR);
        end
        else
        begin
            if (v6)
            begin
                c.ak = c.ak | (is_src ? 2'd1 : 2'd2);
            end
            if (is_src)
            begin
                c.cap_hi = hi;
                c.cap_lo = lo;
            end
        end
        return c;
    endfunction

    function automatic php_ctx_t f_port_finish(input php_ctx_t c, input logic is_src);
        if ((c.ef & EF_TOKBAD) != '0 || c.tlen == 7'd0 || c.tlen > 7'd5
            || c.acc > 17'd65535)
        begin
            c.ef = c.ef | (is_src ? EF_SRCPORT : EF_DSTPORT);
        end
        else if (is_src)
        begin
            c.cap_port = c.acc[15:0];
        end
        return c;
    endfunction

    function automatic php_ctx_t f_end_token(input php_ctx_t c);
        if (c.tlen == 7'd0)
        begin
            c.ef = c.ef | EF_SPACING;
        end
        case (c.tidx)
            3'd0:
            begin
                if ((c.tm & TM_PROXY) == '0 || c.tlen != 7'd5)
                begin
                    c.ef = c.ef | EF_PROXY;
                end
                c.tm = c.tm | TM_UNKNOWN | TM_TCP4 | TM_TCP6;
            end
            3'd1:
            begin
                if (c.tlen != 7'd7)
                begin
                    c.tm = c.tm & ~TM_UNKNOWN;
                end
                if (c.tlen != 7'd4)
                begin
                    c.tm = c.tm & ~(TM_TCP4 | TM_TCP6);
                end
            end
            3'd2:    c = f_addr_finish(c, 1'b1);
            3'd3:    c = f_addr_finish(c, 1'b0);
            3'd4:    c = f_port_finish(c, 1'b1);
            3'd5:    c = f_port_finish(c, 1'b0);
            default: c = c;
        endcase
        c.tlen = '0;
        c.acc  = '0;
        c.dc   = '0;
        c.gc   = '0;
        c.gap  = GAP_NONE;
        c.tm   = c.tm & ~(TM_DOT | TM_COLON | TM_LETTER | TM_COLPREV);
        c.ef   = c.ef & ~(EF_TOKBAD | EF_GAPJUST | EF_LEADCOL);
        if (c.tidx != 3'd7)
        begin
            c.tidx = c.tidx + 3'd1;
        end
        return c;
    endfunction

    function automatic php_ctx_t f_cr_char(input php_ctx_t c);
        if (c.tlen != 7'd127)
        begin
            c.tlen = c.tlen + 7'd1;
        end
        case (c.tidx)
            3'd0:    c.tm = c.tm & ~TM_PROXY;
            3'd1:    c.tm = c.tm & ~(TM_UNKNOWN | TM_TCP4 | TM_TCP6);
            3'd2, 3'd3, 3'd4, 3'd5: c.ef = c.ef | EF_TOKBAD;
            default: c = c;
        endcase
        return c;
    endfunction

    function automatic php_ctx_t f_line_char(input php_ctx_t c, input logic [7:0] ch,
                                             input logic is_space);
        logic [6:0] pos;
        pos = c.tlen;
        if (is_space)
        begin
            c = f_end_token(c);
        end
        else
        begin
            if (c.tlen != 7'd127)
            begin
                c.tlen = c.tlen + 7'd1;
            end
            case (c.tidx)
                3'd0:
                begin
                    if (pos >= 7'd5 || ch != proxy_chr(pos[2:0]))
                    begin
                        c.tm = c.tm & ~TM_PROXY;
                    end
                end
                3'd1:
                begin
                    if (pos >= 7'd7 || ch != unknown_chr(pos[2:0]))
                    begin
                        c.tm = c.tm & ~TM_UNKNOWN;
                    end
                    if (pos < 7'd3)
                    begin
                        if (ch != tcp_chr(pos[1:0]))
                        begin
                            c.tm = c.tm & ~(TM_TCP4 | TM_TCP6);
                        end
                    end
                    else
                    begin
                        if (pos != 7'd3 || ch != "4")
                        begin
                            c.tm = c.tm & ~TM_TCP4;
                        end
                        if (pos != 7'd3 || ch != "6")
                        begin
                            c.tm = c.tm & ~TM_TCP6;
                        end
                    end
                end
                3'd2, 3'd3:
                begin
                    c = f_addr_char(c, ch);
                end
                3'd4, 3'd5:
                begin
                    if (ch < "0" || ch > "9")
                    begin
                        c.ef = c.ef | EF_TOKBAD;
                    end
                    else if (pos < 7'd5)
                    begin
                        c.acc = 17'(c.acc * 17'd10 + {13'd0, ch[3:0]});
                    end
                end
                default: c = c;
            endcase
        end
        return c;
    endfunction

    function automatic php_res_t f_fail(input logic [3:0] err, input logic [16:0] bc);
        php_res_t r;
        r               = '0;
        r.status        = 1'b1;
        r.error_code    = err;
        r.header_length = bc;
        return r;
    endfunction

    function automatic php_res_t f_ok(input logic has, input logic v6, input logic [63:0] hi,
                                      input logic [63:0] lo, input logic [15:0] port,
                                      input logic [16:0] bc);
        php_res_t r;
        r.status           = 1'b0;
        r.error_code       = ERR_NONE;
        r.has_source       = has;
        r.source_is_ipv6   = v6;
        r.source_addr_high = hi;
        r.source_addr_low  = lo;
        r.source_port      = port;
        r.header_length    = bc;
        return r;
    endfunction

    assign rb_pop    = res_pop && !res_empty;
    assign take      = !item_empty && (res_count_reg != 2'(RB_DEPTH) || rb_pop);
    assign item_pop  = take;
    assign eff_phase = item.first ? item.start : phase_reg;

    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_IDLE:
            begin
                if (take && item.first)
                begin
                    phase_next = item.start;
                end
            end
            PH_V1, PH_V2:
            begin
                if (take && item.first)
                begin
                    phase_next = item.start;
                end
            end
            default: phase_next = PH_IDLE;
        endcase
        if (take && res_make)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        logic [7:0]  b;
        logic [16:0] off;
        logic        want6;
        logic        done;
        c_work: begin end
        b        = item.data_byte;
        off      = '0;
        want6    = 1'b0;
        done     = 1'b0;
        ctx_next = ctx_reg;
        res_make = 1'b0;
        res_data = '0;
        if (take)
        begin
            if (item.first)
            begin
                ctx_next    = ctx_clear();
                ctx_next.bc = 17'd1;
                if (item.start == PH_V1)
                begin
                    ctx_next.tm = TM_PROXY;
                end
            end
            else if (phase_reg != PH_IDLE && ctx_next.bc != '1)
            begin
                ctx_next.bc = ctx_next.bc + 17'd1;
            end

            if (item.first && item.start == PH_IDLE)
            begin
                res_make = 1'b1;
                res_data = f_fail(ERR_FIRST, ctx_next.bc);
            end
            else if (eff_phase == PH_V1)
            begin
                if (item.cls == CLS_LF)
                begin
                    res_make = 1'b1;
                    if (!ctx_next.prev_cr)
                    begin
                        res_data = f_fail(ERR_BARE_LF, ctx_next.bc);
                    end
                    else
                    begin
                        ctx_next = f_end_token(ctx_next);
                        want6    = (ctx_next.tm & TM_TCP6) != '0;
                        if ((ctx_next.ef & EF_SPACING) != '0)
                        begin
                            res_data = f_fail(ERR_SPACING, ctx_next.bc);
                        end
                        else if (ctx_next.tidx < 3'd2 || (ctx_next.ef & EF_PROXY) != '0)
                        begin
                            res_data = f_fail(ERR_MALFORMED, ctx_next.bc);
                        end
                        else if ((ctx_next.tm & TM_UNKNOWN) != '0)
                        begin
                            res_data = f_ok(1'b0, 1'b0, '0, '0, '0, ctx_next.bc);
                        end
                        else if ((ctx_next.tm & (TM_TCP4 | TM_TCP6)) == '0)
                        begin
                            res_data = f_fail(ERR_FAMILY, ctx_next.bc);
                        end
                        else if (ctx_next.tidx != 3'd6)
                        begin
                            res_data = f_fail(ERR_TOKENS, ctx_next.bc);
                        end
                        else if ((ctx_next.ef & (EF_SRCADDR | EF_DSTADDR)) != '0)
                        begin
                            res_data = f_fail(ERR_ADDR, ctx_next.bc);
                        end
                        else if (ctx_next.ak != (want6 ? 2'd3 : 2'd0))
                        begin
                            res_data = f_fail(ERR_MISMATCH, ctx_next.bc);
                        end
                        else if ((ctx_next.ef & (EF_SRCPORT | EF_DSTPORT)) != '0)
                        begin
                            res_data = f_fail(ERR_PORT, ctx_next.bc);
                        end
                        else if (want6)
                        begin
                            res_data = f_ok(1'b1, 1'b1, ctx_next.cap_hi, ctx_next.cap_lo,
                                            ctx_next.cap_port, ctx_next.bc);
                        end
                        else
                        begin
                            res_data = f_ok(1'b1, 1'b0, '0, {32'd0, ctx_next.cap_lo[31:0]},
                                            ctx_next.cap_port, ctx_next.bc);
                        end
                    end
                end
                else
                begin
                    if (ctx_next.prev_cr)
                    begin
                        ctx_next         = f_cr_char(ctx_next);
                        ctx_next.prev_cr = 1'b0;
                    end
                    if (item.cls == CLS_CR)
                    begin
                        ctx_next.prev_cr = 1'b1;
                    end
                    else
                    begin
                        ctx_next = f_line_char(ctx_next, b, item.cls == CLS_SPACE);
                    end
                    if (ctx_next.bc >= 17'(V1_MAX_LINE))
                    begin
                        res_make = 1'b1;
                        res_data = f_fail(ERR_LONG, ctx_next.bc);
                    end
                end
            end
            else if (eff_phase == PH_V2)
            begin
                if (ctx_next.bc <= 17'd12)
                begin
                    if (b != sig_byte(4'(ctx_next.bc - 17'd1)))
                    begin
                        ctx_next.sig_ok = 1'b0;
                    end
                end
                else if (ctx_next.bc == 17'd13)
                begin
                    ctx_next.cmd = b;
                end
                else if (ctx_next.bc == 17'd14)
                begin
                    ctx_next.fam = b;
                end
                else if (ctx_next.bc == 17'd15)
                begin
                    ctx_next.blen = {b, 8'd0};
                end
                else if (ctx_next.bc == 17'd16)
                begin
                    ctx_next.blen = {ctx_next.blen[15:8], b};
                end
                else
                begin
                    off = ctx_next.bc - 17'd17;
                    if (ctx_next.fam == 8'h11)
                    begin
                        if (off < 17'd4)
                        begin
                            ctx_next.cap_lo = {32'd0, ctx_next.cap_lo[23:0], b};
                        end
                        else if (off == 17'd8 || off == 17'd9)
                        begin
                            ctx_next.cap_port = {ctx_next.cap_port[7:0], b};
                        end
                    end
                    else if (ctx_next.fam == 8'h21)
                    begin
                        if (off < 17'd8)
                        begin
                            ctx_next.cap_hi = {ctx_next.cap_hi[55:0], b};
                        end
                        else if (off < 17'd16)
                        begin
                            ctx_next.cap_lo = {ctx_next.cap_lo[55:0], b};
                        end
                        else if (off == 17'd32 || off == 17'd33)
                        begin
                            ctx_next.cap_port = {ctx_next.cap_port[7:0], b};
                        end
                    end
                end
                if (ctx_next.bc == 17'd16)
                begin
                    if (!ctx_next.sig_ok)
                    begin
                        done     = 1'b1;
                        res_data = f_fail(ERR_SIG, ctx_next.bc);
                    end
                    else if (ctx_next.cmd[7:4] != 4'h2)
                    begin
                        done     = 1'b1;
                        res_data = f_fail(ERR_VERSION, ctx_next.bc);
                    end
                    else if (ctx_next.cmd[3:0] > 4'd1)
                    begin
                        done     = 1'b1;
                        res_data = f_fail(ERR_COMMAND, ctx_next.bc);
                    end
                end
                if (!done && ctx_next.bc >= 17'd16
                    && ctx_next.bc == 17'd16 + {1'b0, ctx_next.blen})
                begin
                    done = 1'b1;
                    if (ctx_next.cmd[3:0] == 4'd0)
                    begin
                        res_data = f_ok(1'b0, 1'b0, '0, '0, '0, ctx_next.bc);
                    end
                    else if (ctx_next.fam == 8'h11)
                    begin
                        if (ctx_next.blen < 16'd12)
                        begin
                            res_data = f_fail(ERR_V4_SHORT, ctx_next.bc);
                        end
                        else
                        begin
                            res_data = f_ok(1'b1, 1'b0, '0, ctx_next.cap_lo,
                                            ctx_next.cap_port, ctx_next.bc);
                        end
                    end
                    else if (ctx_next.fam == 8'h21)
                    begin
                        if (ctx_next.blen < 16'd36)
                        begin
                            res_data = f_fail(ERR_V6_SHORT, ctx_next.bc);
                        end
                        else
                        begin
                            res_data = f_ok(1'b1, 1'b1, ctx_next.cap_hi, ctx_next.cap_lo,
                                            ctx_next.cap_port, ctx_next.bc);
                        end
                    end
                    else
                    begin
                        res_data = f_ok(1'b0, 1'b0, '0, '0, '0, ctx_next.bc);
                    end
                end
                res_make = done;
            end
        end
    end

    assign rb_push   = take && res_make;
    assign res_empty = (res_count_reg == 2'd0);
    assign res       = rb_reg[rb_rd_reg];

    always_comb
    begin
        res_count_next = res_count_reg;
        if (rb_push && !rb_pop)
        begin
            res_count_next = res_count_reg + 2'd1;
        end
        else if (!rb_push && rb_pop)
        begin
            res_count_next = res_count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            ctx_reg       <= ctx_clear();
            rb_wr_reg     <= 1'b0;
            rb_rd_reg     <= 1'b0;
            res_count_reg <= 2'd0;
        end
        else
        begin
            phase_reg     <= phase_next;
            ctx_reg       <= ctx_next;
            rb_wr_reg     <= rb_push ? ~rb_wr_reg : rb_wr_reg;
            rb_rd_reg     <= rb_pop ? ~rb_rd_reg : rb_rd_reg;
            res_count_reg <= res_count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rb_push)
        begin
            rb_reg[rb_wr_reg] <= res_data;
        end
    end

    `PHP_ASSERT_IMP(a_rb_bound, 1'b1, res_count_reg <= 2'(RB_DEPTH))
    `PHP_ASSERT_NXT(a_emit_idle, take && res_make, phase_reg == PH_IDLE)
    `PHP_ASSERT_IMP(a_idle_quiet, take && !item.first && phase_reg == PH_IDLE, !res_make)

endmodule

`default_nettype wire

// ===== sv/proxy_header_parser_top.sv =====
// ----------------------------------------------------------------------------
// PROXY header parser top level
// Parses v1 text and v2 binary PROXY headers, one byte per beat.
// ----------------------------------------------------------------------------
//  channel | handshake     | payload
//  --------+---------------+------------------------------------------------
//  bytes   | push / full   | data_byte, first
//  results | empty / pop   | status, error_code, has_source, source_is_ipv6,
//          |               | source_addr_high, source_addr_low, source_port,
//          |               | header_length
//
//  One byte per cycle sustained while results are taken; the byte that completes
//  a header is registered in the item queue, its result in the result buffer.
//  Reset clears the parser to idle; no clearing pass is needed.
//  A full result buffer holds the core; the four-beat byte queue then fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module proxy_header_parser_top
    import php_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        push,
    output logic             full,
    input  wire logic [7:0]  data_byte,
    input  wire logic        first,
    output logic             empty,
    input  wire logic        pop,
    output logic             status,
    output logic [3:0]       error_code,
    output logic             has_source,
    output logic             source_is_ipv6,
    output logic [63:0]      source_addr_high,
    output logic [63:0]      source_addr_low,
    output logic [15:0]      source_port,
    output logic [16:0]      header_length
);

    php_item_t in_item;
    php_item_t q_item;
    logic      q_empty;
    logic      q_pop;
    php_res_t  res;

    php_front u_front (
        .data_byte (data_byte),
        .first     (first),
        .item      (in_item)
    );

    php_item_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_item (in_item),
        .full    (full),
        .pop     (q_pop),
        .rd_item (q_item),
        .empty   (q_empty)
    );

    php_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .item       (q_item),
        .item_empty (q_empty),
        .item_pop   (q_pop),
        .res        (res),
        .res_empty  (empty),
        .res_pop    (pop)
    );

    assign status           = res.status;
    assign error_code       = res.error_code;
    assign has_source       = res.has_source;
    assign source_is_ipv6   = res.source_is_ipv6;
    assign source_addr_high = res.source_addr_high;
    assign source_addr_low  = res.source_addr_low;
    assign source_port      = res.source_port;
    assign header_length    = res.header_length;

endmodule

`default_nettype wire
